// File: hw/rtl/snc_pkg.sv
// ----------------------------------------------------------------------------
// snc_pkg
// Shared types and constants of the sliding normalized correlation detector.
// ----------------------------------------------------------------------------
package snc_pkg;

    // Opcodes carried on the input tuser bit.
    localparam logic OP_REF_LOAD = 1'b0;
    localparam logic OP_SAMPLE   = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_WINDOW    = 1'b1;

    localparam int CFG_WIDTH      = 15;
    localparam int THR_RESET      = 32440;
    localparam int WIN_RESET      = 256;
    localparam int CORR_BITS      = 16;
    localparam int QUOT_BITS      = 17;
    localparam int NORM_BITS      = 31;
    localparam int REF_INDEX_BITS = 8;
    localparam int OUT_TDATA_W    = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_CHK,
        ST_NORM,
        ST_SQM,
        ST_ROOT_GO,
        ST_ROOT,
        ST_DIV_GO,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

// File: hw/rtl/snc_ram.sv
// ----------------------------------------------------------------------------
// snc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module snc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/snc_isqrt.sv
// ----------------------------------------------------------------------------
// snc_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module snc_isqrt #(
    parameter int RW = 31
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] x_reg,    x_next;
    logic [RW+2:0]   rem_reg,  rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg,  cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // Bring down the next two radicand bits and try to subtract 4*root+1.
    assign rem_sh = {rem_reg[RW:0], x_reg[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[2*RW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/snc_div.sv
// ----------------------------------------------------------------------------
// snc_div
// Restoring divider producing QW quotient bits, one per cycle.
// ----------------------------------------------------------------------------
module snc_div #(
    parameter int DW = 31,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [DW+1:0] r_reg,    r_next;
    logic [QW-1:0] q_reg,    q_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW+1:0] d_ext;
    logic [DW+1:0] r_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign d_ext = (DW+2)'(divisor);
    assign r_sub = r_reg - d_ext;

    // The dividend is below twice the divisor, so the quotient fits in QW bits.
    always_comb
    begin
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            r_next    = {1'b0, dividend};
            q_next    = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (r_reg >= d_ext)
            begin
                r_next = {r_sub[DW:0], 1'b0};
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW:0], 1'b0};
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: hw/rtl/sliding_normalized_correlation_detector.sv
// Flow: a sample that completes the window is followed by a pass over the window
// and reference RAMs, the shared multiplier steps, normalization, the root and the
// divide before its result; a zero variance skips straight to the result.
// Throughput: one item at a time; a reference load or a sample that does not
// complete the window leaves the detector idle. Reset clears pointers, fill count,
// output and configuration; RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
// sliding_normalized_correlation_detector
// Pearson correlation of a sliding sample window with a stored reference.
// ----------------------------------------------------------------------------
module sliding_normalized_correlation_detector #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] ref_index, [8 +: SAMPLE_BITS] value, zero padded
    input  logic [((8+SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    // [0] op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] correlation, [16] detected, zero padded
    output logic [snc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [snc_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int LW   = $clog2(WINDOW_MAX + 1);
    localparam int SUMW = SAMPLE_BITS + LW;
    localparam int SQW  = 2*SAMPLE_BITS + LW;
    localparam int VW   = 2*SAMPLE_BITS + 2*LW + 1;
    localparam int NW   = (VW > 33) ? VW : 33;
    localparam int MW   = (SQW > 32) ? SQW : 32;
    localparam int SHW  = $clog2(NW + 1);
    localparam int RW   = snc_pkg::NORM_BITS;
    localparam int QW   = snc_pkg::QUOT_BITS;
    // The narrow multiplier operand only ever carries n, a sum or a variance.
    localparam int OW   = (SUMW > RW + 1) ? SUMW : RW + 1;

    snc_pkg::state_t state_reg, state_next;

    logic [snc_pkg::CFG_WIDTH-1:0] thr_reg, thr_next;
    logic [snc_pkg::CFG_WIDTH-1:0] wl_reg,  wl_next;
    logic [AW-1:0]  wp_reg,   wp_next;
    logic [LW-1:0]  fill_reg, fill_next;
    logic [LW-1:0]  n_reg,    n_next;
    logic [LW-1:0]  cnt_reg,  cnt_next;
    logic [AW-1:0]  idx_reg,  idx_next;
    logic           rdv_reg,  rdv_next;
    logic [2:0]     mstep_reg, mstep_next;

    logic signed [SUMW-1:0] sa_reg,  sa_next;
    logic signed [SUMW-1:0] sb_reg,  sb_next;
    logic signed [SQW-1:0]  sab_reg, sab_next;
    logic signed [SQW-1:0]  saa_reg, saa_next;
    logic signed [SQW-1:0]  sbb_reg, sbb_next;
    logic signed [2*MW-1:0] p_reg,   p_next;
    logic signed [VW-1:0]   t_reg,   t_next;
    logic signed [VW-1:0]   c_reg,   c_next;
    logic [NW-1:0]  va_reg,  va_next;
    logic [NW-1:0]  vb_reg,  vb_next;
    logic [NW-1:0]  cm_reg,  cm_next;
    logic [NW-1:0]  m_reg,   m_next;
    logic [SHW-1:0] sha_reg, sha_next;
    logic [SHW-1:0] shb_reg, shb_next;
    logic           neg_reg, neg_next;
    logic [QW-1:0]  q_reg,   q_next;

    logic           out_valid_reg, out_valid_next;
    logic [snc_pkg::CORR_BITS-1:0] out_corr_reg, out_corr_next;
    logic           out_det_reg,   out_det_next;

    logic [7:0]                    in_ref_index;
    logic signed [SAMPLE_BITS-1:0] in_value;
    logic                          accept;
    logic                          smp_we, ref_we;
    logic [SAMPLE_BITS-1:0]        smp_rdata, ref_rdata;
    logic [AW-1:0]                 ref_raddr;
    logic [AW-1:0]                 wp_inc;
    logic [LW-1:0]                 fill_inc;
    logic [LW-1:0]                 n_sel;
    logic [LW:0]                   start_tmp;
    logic [AW-1:0]                 start_idx;

    logic signed [SAMPLE_BITS-1:0]   a_s, b_s;
    logic signed [2*SAMPLE_BITS-1:0] ab, aa, bb;
    logic signed [OW-1:0]            mul_a;
    logic signed [MW-1:0]            mul_b;
    logic signed [VW-1:0]            p_trunc;
    logic                            big_a, big_b;
    logic [SHW:0]                    sh_sum;

    logic           root_start, root_done;
    logic [RW-1:0]  root;
    logic           div_start,  div_done;
    logic [QW-2:0]  quot;
    logic [QW-1:0]  q_lim;
    logic [snc_pkg::CORR_BITS-1:0] corr;
    logic           ovf;

    assign in_ref_index = s_tdata[7:0];
    assign in_value     = s_tdata[8 +: SAMPLE_BITS];
    assign s_tready     = (state_reg == snc_pkg::ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign smp_we       = accept && (s_tuser == snc_pkg::OP_SAMPLE);
    assign ref_we       = accept && (s_tuser == snc_pkg::OP_REF_LOAD)
                          && (32'(in_ref_index) < WINDOW_MAX);
    assign ref_raddr    = AW'(cnt_reg);

    snc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_sample_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (wp_reg),
        .wdata (in_value),
        .raddr (idx_reg),
        .rdata (smp_rdata)
    );

    snc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (AW'(in_ref_index)),
        .wdata (in_value),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    snc_isqrt #(
        .RW (RW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (p_reg[2*RW-1:0]),
        .done     (root_done),
        .root     (root)
    );

    snc_div #(
        .DW (RW),
        .QW (QW-1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (m_reg[RW:0]),
        .divisor  (root),
        .done     (div_done),
        .quotient (quot)
    );

    // Window bookkeeping for an incoming sample.
    assign wp_inc   = (wp_reg == AW'(WINDOW_MAX-1)) ? '0 : wp_reg + 1'b1;
    assign fill_inc = (fill_reg == LW'(WINDOW_MAX)) ? fill_reg : fill_reg + 1'b1;
    assign n_sel    = (wl_reg < 15'd2) ? LW'(2) :
                      (32'(wl_reg) > WINDOW_MAX) ? LW'(WINDOW_MAX) : LW'(wl_reg);
    assign start_tmp = (LW+1)'(wp_inc) + (LW+1)'(WINDOW_MAX) - (LW+1)'(n_sel);
    assign start_idx = (start_tmp >= (LW+1)'(WINDOW_MAX)) ?
                       AW'(start_tmp - (LW+1)'(WINDOW_MAX)) : AW'(start_tmp);

    // Accumulation products.
    assign a_s = smp_rdata;
    assign b_s = ref_rdata;
    assign ab  = a_s * b_s;
    assign aa  = a_s * a_s;
    assign bb  = b_s * b_s;

    // Shared multiplier operand select.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == snc_pkg::ST_SQM)
        begin
            mul_a = OW'(va_reg[RW-1:0]);
            mul_b = MW'(vb_reg[RW-1:0]);
        end
        else
        begin
            case (mstep_reg)
                3'd0:
                begin
                    mul_a = OW'(n_reg);
                    mul_b = MW'(sab_reg);
                end
                3'd1:
                begin
                    mul_a = OW'(sa_reg);
                    mul_b = MW'(sb_reg);
                end
                3'd2:
                begin
                    mul_a = OW'(n_reg);
                    mul_b = MW'(saa_reg);
                end
                3'd3:
                begin
                    mul_a = OW'(sa_reg);
                    mul_b = MW'(sa_reg);
                end
                3'd4:
                begin
                    mul_a = OW'(n_reg);
                    mul_b = MW'(sbb_reg);
                end
                3'd5:
                begin
                    mul_a = OW'(sb_reg);
                    mul_b = MW'(sb_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign p_trunc = VW'(p_reg);
    assign big_a   = |va_reg[NW-1:RW];
    assign big_b   = |vb_reg[NW-1:RW];
    assign sh_sum  = (SHW+1)'(sha_reg) + (SHW+1)'(shb_reg);
    assign ovf     = m_reg >= NW'({root, 1'b0});

    // Final sign handling and saturation.
    assign q_lim = (q_reg > QW'(32768)) ? QW'(32768) : q_reg;
    always_comb
    begin
        if (neg_reg)
        begin
            corr = snc_pkg::CORR_BITS'(QW'(0) - q_lim);
        end
        else if (q_lim > QW'(32767))
        begin
            corr = 16'h7fff;
        end
        else
        begin
            corr = snc_pkg::CORR_BITS'(q_lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snc_pkg::ST_IDLE;
            thr_reg       <= snc_pkg::CFG_WIDTH'(snc_pkg::THR_RESET);
            wl_reg        <= snc_pkg::CFG_WIDTH'(snc_pkg::WIN_RESET);
            wp_reg        <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rdv_reg       <= 1'b0;
            mstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            wl_reg        <= wl_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            rdv_reg       <= rdv_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        sab_reg      <= sab_next;
        saa_reg      <= saa_next;
        sbb_reg      <= sbb_next;
        p_reg        <= p_next;
        t_reg        <= t_next;
        c_reg        <= c_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        cm_reg       <= cm_next;
        m_reg        <= m_next;
        sha_reg      <= sha_next;
        shb_reg      <= shb_next;
        neg_reg      <= neg_next;
        q_reg        <= q_next;
        out_corr_reg <= out_corr_next;
        out_det_reg  <= out_det_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        wl_next        = wl_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rdv_next       = 1'b0;
        mstep_next     = mstep_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        sab_next       = sab_reg;
        saa_next       = saa_reg;
        sbb_next       = sbb_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        c_next         = c_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        cm_next        = cm_reg;
        m_next         = m_reg;
        sha_next       = sha_reg;
        shb_next       = shb_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        out_corr_next  = out_corr_reg;
        out_det_next   = out_det_reg;
        out_valid_next = out_valid_reg && !m_tready;
        root_start     = 1'b0;
        div_start      = 1'b0;

        if (cfg_wr_en)
        begin
            if (cfg_index == snc_pkg::CFG_THRESHOLD)
            begin
                thr_next = cfg_wdata;
            end
            else
            begin
                wl_next = cfg_wdata;
            end
        end

        case (state_reg)
            snc_pkg::ST_IDLE:
            begin
                if (smp_we)
                begin
                    wp_next   = wp_inc;
                    fill_next = fill_inc;
                    if (fill_inc >= n_sel)
                    begin
                        n_next     = n_sel;
                        cnt_next   = '0;
                        idx_next   = start_idx;
                        sa_next    = '0;
                        sb_next    = '0;
                        sab_next   = '0;
                        saa_next   = '0;
                        sbb_next   = '0;
                        state_next = snc_pkg::ST_ACC;
                    end
                end
            end

            snc_pkg::ST_ACC:
            begin
                if (cnt_reg != n_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = (idx_reg == AW'(WINDOW_MAX-1)) ? '0 : idx_reg + 1'b1;
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    sa_next  = sa_reg + SUMW'(a_s);
                    sb_next  = sb_reg + SUMW'(b_s);
                    sab_next = sab_reg + SQW'(ab);
                    saa_next = saa_reg + SQW'(aa);
                    sbb_next = sbb_reg + SQW'(bb);
                end
                else if (cnt_reg == n_reg)
                begin
                    mstep_next = '0;
                    state_next = snc_pkg::ST_MUL;
                end
            end

            snc_pkg::ST_MUL:
            begin
                // Each product is registered and consumed one step later.
                p_next     = mul_a * mul_b;
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    3'd1, 3'd3, 3'd5:
                    begin
                        t_next = p_trunc;
                    end
                    3'd2:
                    begin
                        c_next = t_reg - p_trunc;
                    end
                    3'd4:
                    begin
                        va_next = NW'(t_reg - p_trunc);
                    end
                    3'd6:
                    begin
                        vb_next    = NW'(t_reg - p_trunc);
                        state_next = snc_pkg::ST_CHK;
                    end
                    default:
                    begin
                        t_next = t_reg;
                    end
                endcase
            end

            snc_pkg::ST_CHK:
            begin
                sha_next = '0;
                shb_next = '0;
                neg_next = c_reg[VW-1];
                cm_next  = c_reg[VW-1] ? NW'(-c_reg) : NW'(c_reg);
                if (va_reg == '0 || vb_reg == '0)
                begin
                    neg_next   = 1'b0;
                    q_next     = '0;
                    state_next = snc_pkg::ST_FIN;
                end
                else
                begin
                    state_next = snc_pkg::ST_NORM;
                end
            end

            snc_pkg::ST_NORM:
            begin
                // Shift both variances down to 31 bits; keep the total shift even.
                if (big_a || big_b)
                begin
                    if (big_a)
                    begin
                        va_next  = va_reg >> 1;
                        sha_next = sha_reg + 1'b1;
                    end
                    if (big_b)
                    begin
                        vb_next  = vb_reg >> 1;
                        shb_next = shb_reg + 1'b1;
                    end
                end
                else
                begin
                    if (sh_sum[0])
                    begin
                        if (sha_reg != '0)
                        begin
                            va_next  = va_reg >> 1;
                            sha_next = sha_reg + 1'b1;
                        end
                        else
                        begin
                            vb_next  = vb_reg >> 1;
                            shb_next = shb_reg + 1'b1;
                        end
                    end
                    state_next = snc_pkg::ST_SQM;
                end
            end

            snc_pkg::ST_SQM:
            begin
                p_next     = mul_a * mul_b;
                m_next     = cm_reg >> sh_sum[SHW:1];
                state_next = snc_pkg::ST_ROOT_GO;
            end

            snc_pkg::ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = snc_pkg::ST_ROOT;
            end

            snc_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    if (root == '0)
                    begin
                        neg_next   = 1'b0;
                        q_next     = '0;
                        state_next = snc_pkg::ST_FIN;
                    end
                    else if (ovf)
                    begin
                        q_next     = QW'(32768);
                        state_next = snc_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = snc_pkg::ST_DIV_GO;
                    end
                end
            end

            snc_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = snc_pkg::ST_DIV;
            end

            snc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    q_next     = QW'(quot);
                    state_next = snc_pkg::ST_FIN;
                end
            end

            snc_pkg::ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_corr_next  = corr;
                    // Compare the saturated value, so a full-scale result never
                    // beats the largest threshold.
                    out_det_next   = !neg_reg &&
                                     (corr > snc_pkg::CORR_BITS'(thr_reg));
                    state_next     = snc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = snc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_det_reg, out_corr_reg};

endmodule
